// ===== sv/hcc_pkg.sv =====
package hcc_pkg;

  // Fixed field widths
  localparam int unsigned LevelW  = 8;
  localparam int unsigned ClassW  = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 8;

  // Overexposure map geometry
  localparam int unsigned MapSide = 256;

  // Fixed-point HSV constants
  localparam int unsigned OverLevel = 250;
  localparam int unsigned HsvShift  = 12;
  localparam int unsigned HueScale  = 21;
  localparam int unsigned HueRange  = 255;
  localparam int unsigned RecipNum  = 1044480;
  localparam int unsigned HueShift  = HsvShift + 7;

  // Datapath widths
  localparam int unsigned RecipW    = 20;                       // round(1044480 / n)
  localparam int unsigned Recip21W  = 25;                       // reciprocal times hue scale
  localparam int unsigned HueNumW   = 12;                       // signed hue numerator
  localparam int unsigned SatProdW  = LevelW + RecipW;
  localparam int unsigned HueProdW  = HueNumW + Recip21W + 1;
  localparam int unsigned HueW      = HueProdW - HueShift;

  // Classify pipeline: s1, s2, s3, output register
  localparam int unsigned PipeDepth = 4;

  // Item kinds
  localparam logic KindClassify = 1'b0;
  localparam logic KindMapWrite = 1'b1;

  // Result classes
  localparam logic [ClassW-1:0] ClassNone     = 3'd0;
  localparam logic [ClassW-1:0] ClassCredible = 3'd1;
  localparam logic [ClassW-1:0] MaxClass      = 3'd4;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgHueLow       = 3'd0,
    CfgHueHigh      = 3'd1,
    CfgTargetIsBlue = 3'd2,
    CfgValueFloor   = 3'd3,
    CfgSatFloor     = 3'd4
  } cfg_reg_e;

  // Reset values
  localparam logic [LevelW-1:0] HueLowRst    = 8'd157;
  localparam logic [LevelW-1:0] HueHighRst   = 8'd165;
  localparam logic              TargetBlueRst = 1'b1;
  localparam logic [LevelW-1:0] ValueFloorRst = 8'd127;
  localparam logic [LevelW-1:0] SatFloorRst   = 8'd204;

  typedef struct packed {
    logic [LevelW-1:0] hue_low;
    logic [LevelW-1:0] hue_high;
    logic              target_is_blue;
    logic [LevelW-1:0] value_floor;
    logic [LevelW-1:0] saturation_floor;
  } cfg_t;

endpackage

// ===== sv/hcc_map_ram.sv =====
module hcc_map_ram #(
  parameter int unsigned AddrW = 16
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [hcc_pkg::ClassW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [hcc_pkg::ClassW-1:0] rdata_o
);

  logic [hcc_pkg::ClassW-1:0] mem_q [2**AddrW];
  logic [hcc_pkg::ClassW-1:0] rdata_q;

  // A read in the cycle after a write to the same entry sees the new data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/hcc_recip_rom.sv =====
module hcc_recip_rom (
  input  logic [hcc_pkg::LevelW-1:0]   v_i,
  input  logic [hcc_pkg::LevelW-1:0]   diff_i,
  output logic [hcc_pkg::RecipW-1:0]   rcp_v_o,
  output logic [hcc_pkg::Recip21W-1:0] rcp21_diff_o
);

  localparam int unsigned RcpW   = hcc_pkg::RecipW;
  localparam int unsigned Rcp21W = hcc_pkg::Recip21W;
  localparam int unsigned Depth  = 2**hcc_pkg::LevelW;

  logic [RcpW-1:0]   rcp_tab   [Depth];
  logic [Rcp21W-1:0] rcp21_tab [Depth];

  // Constant tables, built at elaboration; entry zero reads as zero.
  for (genvar n = 0; n < Depth; n++) begin : g_tab
    localparam int unsigned Den = (n == 0) ? 1 : n;
    localparam int unsigned Rcp = (n == 0) ? 0 : (hcc_pkg::RecipNum + Den / 2) / Den;
    assign rcp_tab[n]   = RcpW'(Rcp);
    assign rcp21_tab[n] = Rcp21W'(Rcp * hcc_pkg::HueScale);
  end

  assign rcp_v_o      = rcp_tab[v_i];
  assign rcp21_diff_o = rcp21_tab[diff_i];

endmodule

// ===== sv/hcc_datapath.sv =====
module hcc_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hcc_pkg::cfg_t               cfg_i,
  input  logic                        cls_valid_i,
  output logic                        cls_ready_o,
  input  logic [hcc_pkg::LevelW-1:0]  blue_i,
  input  logic [hcc_pkg::LevelW-1:0]  green_i,
  input  logic [hcc_pkg::LevelW-1:0]  red_i,
  input  logic [hcc_pkg::ClassW-1:0]  map_class_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hcc_pkg::ClassW-1:0]  class_o
);

  localparam int unsigned LevelW   = hcc_pkg::LevelW;
  localparam int unsigned ClassW   = hcc_pkg::ClassW;
  localparam int unsigned RcpW     = hcc_pkg::RecipW;
  localparam int unsigned Rcp21W   = hcc_pkg::Recip21W;
  localparam int unsigned HueNumW  = hcc_pkg::HueNumW;
  localparam int unsigned SatProdW = hcc_pkg::SatProdW;
  localparam int unsigned HueProdW = hcc_pkg::HueProdW;
  localparam int unsigned HueW     = hcc_pkg::HueW;
  localparam int unsigned HsvShift = hcc_pkg::HsvShift;
  localparam int unsigned HueShift = hcc_pkg::HueShift;
  localparam int unsigned SatW     = SatProdW - HsvShift;

  localparam logic [LevelW-1:0]          OverLvl = LevelW'(hcc_pkg::OverLevel);
  localparam logic signed [HueProdW-1:0] HueHalf = HueProdW'(1) << (HueShift - 1);
  localparam logic signed [HueW-1:0]     HueWrap = HueW'(hcc_pkg::HueRange);

  // Stage ready chain
  logic s1_rdy, s2_rdy, s3_rdy, out_rdy;

  // Stage 0: max, min, spread, early decisions
  logic [LevelW-1:0] v0, vmin0, diff0, target0;
  logic              dark0, over0, vr0, vg0;

  always_comb begin
    v0 = blue_i;
    if (green_i > v0) v0 = green_i;
    if (red_i > v0)   v0 = red_i;
    vmin0 = blue_i;
    if (green_i < vmin0) vmin0 = green_i;
    if (red_i < vmin0)   vmin0 = red_i;
  end

  assign diff0   = v0 - vmin0;
  assign target0 = cfg_i.target_is_blue ? blue_i : red_i;
  assign dark0   = (v0 <= cfg_i.value_floor);
  assign over0   = (target0 >= OverLvl);
  assign vr0     = (v0 == red_i);
  assign vg0     = (v0 == green_i);

  logic              s1_valid_q, s1_valid_d;
  logic              s1_dark_q, s1_over_q, s1_vr_q, s1_vg_q;
  logic [LevelW-1:0] s1_v_q, s1_diff_q, s1_b_q, s1_g_q, s1_r_q;

  // Stage 1: reciprocal lookups, hue numerator
  logic [RcpW-1:0]            rcp_v1;
  logic [Rcp21W-1:0]          rcp21_1;
  logic signed [HueNumW-1:0]  b1, g1, r1, d1, h1;

  hcc_recip_rom u_rom (
    .v_i          (s1_v_q),
    .diff_i       (s1_diff_q),
    .rcp_v_o      (rcp_v1),
    .rcp21_diff_o (rcp21_1)
  );

  assign b1 = $signed(HueNumW'(s1_b_q));
  assign g1 = $signed(HueNumW'(s1_g_q));
  assign r1 = $signed(HueNumW'(s1_r_q));
  assign d1 = $signed(HueNumW'(s1_diff_q));

  always_comb begin
    if (s1_vr_q) begin
      h1 = g1 - b1;
    end else if (s1_vg_q) begin
      h1 = b1 - r1 + (d1 <<< 1);
    end else begin
      h1 = r1 - g1 + (d1 <<< 2);
    end
  end

  logic                       s2_valid_q;
  logic                       s2_dark_q, s2_over_q;
  logic [ClassW-1:0]          s2_map_q;
  logic [LevelW-1:0]          s2_diff_q;
  logic [RcpW-1:0]            s2_rcp_q;
  logic [Rcp21W-1:0]          s2_rcp21_q;
  logic signed [HueNumW-1:0]  s2_h_q;

  // Stage 2: the two multiplications
  logic [SatProdW-1:0]        sat_prod2;
  logic signed [HueProdW-1:0] hue_prod2;

  assign sat_prod2 = SatProdW'(s2_diff_q) * SatProdW'(s2_rcp_q);
  assign hue_prod2 = s2_h_q * $signed({1'b0, s2_rcp21_q});

  logic                       s3_valid_q;
  logic                       s3_dark_q, s3_over_q;
  logic [ClassW-1:0]          s3_map_q;
  logic [SatProdW-1:0]        s3_sat_prod_q;
  logic signed [HueProdW-1:0] s3_hue_prod_q;

  // Stage 3: rounding, wrap, threshold compares
  logic [SatW-1:0]            sat3;
  logic signed [HueProdW-1:0] hue_sum3;
  logic signed [HueW-1:0]     hue_sh3, hue3, lo3, hi3;
  logic                       sat_ok3, hue_ok3;
  logic [ClassW-1:0]          class3;

  assign sat3     = s3_sat_prod_q[SatProdW-1:HsvShift];
  assign sat_ok3  = (sat3 > SatW'(cfg_i.saturation_floor));
  assign hue_sum3 = s3_hue_prod_q + HueHalf;
  assign hue_sh3  = hue_sum3[HueProdW-1:HueShift];      // floor shift
  assign hue3     = (hue_sh3 < 0) ? hue_sh3 + HueWrap : hue_sh3;
  assign lo3      = $signed({{(HueW-LevelW){1'b0}}, cfg_i.hue_low});
  assign hi3      = $signed({{(HueW-LevelW){1'b0}}, cfg_i.hue_high});
  assign hue_ok3  = (lo3 < hue3) && (hue3 < hi3);

  always_comb begin
    if (s3_dark_q) begin
      class3 = hcc_pkg::ClassNone;
    end else if (s3_over_q) begin
      class3 = s3_map_q;
    end else if (sat_ok3 && hue_ok3) begin
      class3 = hcc_pkg::ClassCredible;
    end else begin
      class3 = hcc_pkg::ClassNone;
    end
  end

  logic              out_valid_q;
  logic [ClassW-1:0] out_class_q;

  assign out_rdy     = !out_valid_q || out_ready_i;
  assign s3_rdy      = !s3_valid_q || out_rdy;
  assign s2_rdy      = !s2_valid_q || s3_rdy;
  assign s1_rdy      = !s1_valid_q || s2_rdy;
  assign cls_ready_o = s1_rdy;
  assign s1_valid_d  = cls_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_rdy)  s1_valid_q  <= s1_valid_d;
      if (s2_rdy)  s2_valid_q  <= s1_valid_q;
      if (s3_rdy)  s3_valid_q  <= s2_valid_q;
      if (out_rdy) out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && cls_valid_i) begin
      s1_dark_q <= dark0;
      s1_over_q <= over0;
      s1_vr_q   <= vr0;
      s1_vg_q   <= vg0;
      s1_v_q    <= v0;
      s1_diff_q <= diff0;
      s1_b_q    <= blue_i;
      s1_g_q    <= green_i;
      s1_r_q    <= red_i;
    end
    // map read data lands while the transaction sits in s1
    if (s2_rdy && s1_valid_q) begin
      s2_dark_q  <= s1_dark_q;
      s2_over_q  <= s1_over_q;
      s2_map_q   <= map_class_i;
      s2_diff_q  <= s1_diff_q;
      s2_rcp_q   <= rcp_v1;
      s2_rcp21_q <= rcp21_1;
      s2_h_q     <= h1;
    end
    if (s3_rdy && s2_valid_q) begin
      s3_dark_q     <= s2_dark_q;
      s3_over_q     <= s2_over_q;
      s3_map_q      <= s2_map_q;
      s3_sat_prod_q <= sat_prod2;
      s3_hue_prod_q <= hue_prod2;
    end
    if (out_rdy && s3_valid_q) begin
      out_class_q <= class3;
    end
  end

  assign out_valid_o = out_valid_q;
  assign class_o     = out_class_q;

endmodule

// ===== sv/hsv_color_confidence_classifier.sv =====
// A classify result passes through the s1, s2, s3 and output registers before it is valid.
// Throughput: one transaction per cycle (classify or map write) unless the output stalls; each
// takes one map access at accept, and a map write is seen by a classify in the next cycle.
// Map write transactions produce no result; a stalled output backs up four slots.
// Reset (rst_ni low, async): pipeline emptied, registers back to defaults;
// the overexposure map is not cleared and holds garbage until written.
module hsv_color_confidence_classifier #(
  parameter int unsigned MapSide = hcc_pkg::MapSide
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hcc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hcc_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic [hcc_pkg::LevelW-1:0]   blue_level_i,
  input  logic [hcc_pkg::LevelW-1:0]   green_level_i,
  input  logic [hcc_pkg::LevelW-1:0]   red_level_i,
  input  logic [hcc_pkg::LevelW-1:0]   map_row_i,
  input  logic [hcc_pkg::LevelW-1:0]   map_col_i,
  input  logic [hcc_pkg::ClassW-1:0]   map_class_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [hcc_pkg::ClassW-1:0]   confidence_class_o
);

  localparam int unsigned SideW  = $clog2(MapSide);
  localparam int unsigned AddrW  = 2 * SideW;
  localparam int unsigned ClassW = hcc_pkg::ClassW;
  localparam int unsigned LevelW = hcc_pkg::LevelW;

  hcc_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_low          <= hcc_pkg::HueLowRst;
      cfg_q.hue_high         <= hcc_pkg::HueHighRst;
      cfg_q.target_is_blue   <= hcc_pkg::TargetBlueRst;
      cfg_q.value_floor      <= hcc_pkg::ValueFloorRst;
      cfg_q.saturation_floor <= hcc_pkg::SatFloorRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hcc_pkg::CfgHueLow:       cfg_q.hue_low          <= cfg_data_i[LevelW-1:0];
        hcc_pkg::CfgHueHigh:      cfg_q.hue_high         <= cfg_data_i[LevelW-1:0];
        hcc_pkg::CfgTargetIsBlue: cfg_q.target_is_blue   <= cfg_data_i[0];
        hcc_pkg::CfgValueFloor:   cfg_q.value_floor      <= cfg_data_i[LevelW-1:0];
        hcc_pkg::CfgSatFloor:     cfg_q.saturation_floor <= cfg_data_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

  logic              accept, is_cls, map_we, map_re, cls_ready;
  logic [AddrW-1:0]  waddr, raddr;
  logic [LevelW-1:0] row_sel;
  logic [ClassW-1:0] wclass, rclass;

  assign is_cls  = (kind_i == hcc_pkg::KindClassify);
  assign accept  = in_valid_i && cls_ready;
  assign map_we  = accept && (kind_i == hcc_pkg::KindMapWrite);
  assign map_re  = accept && is_cls;
  assign row_sel = cfg_q.target_is_blue ? red_level_i : blue_level_i;
  assign waddr   = {map_row_i[SideW-1:0], map_col_i[SideW-1:0]};
  assign raddr   = {row_sel[SideW-1:0], green_level_i[SideW-1:0]};
  // codes above the top class store as not credible
  assign wclass  = (map_class_i > hcc_pkg::MaxClass) ? hcc_pkg::ClassNone : map_class_i;

  hcc_map_ram #(
    .AddrW (AddrW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (waddr),
    .wdata_i (wclass),
    .re_i    (map_re),
    .raddr_i (raddr),
    .rdata_o (rclass)
  );

  hcc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cls_valid_i (in_valid_i && is_cls),
    .cls_ready_o (cls_ready),
    .blue_i      (blue_level_i),
    .green_i     (green_level_i),
    .red_i       (red_level_i),
    .map_class_i (rclass),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .class_o     (confidence_class_o)
  );

  assign in_ready_o = cls_ready;

endmodule

// ===== sv/hcc_checker.sv =====
module hcc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         kind_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [hcc_pkg::ClassW-1:0]   confidence_class_o
);

  localparam int unsigned PendW = $clog2(hcc_pkg::PipeDepth + 1);
  localparam logic [PendW-1:0] Full = PendW'(hcc_pkg::PipeDepth);

  logic             cls_in, res_out;
  logic [PendW-1:0] pend_q, pend_d;

  // classify transactions accepted but not yet delivered
  assign cls_in  = in_valid_i && in_ready_o && (kind_i == hcc_pkg::KindClassify);
  assign res_out = out_valid_o && out_ready_i;
  assign pend_d  = pend_q + PendW'(cls_in) - PendW'(res_out);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(confidence_class_o))
    else $error("result changed or dropped while stalled");

  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> confidence_class_o <= hcc_pkg::MaxClass)
    else $error("result class out of range");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("result without a pending classify transaction");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == Full && !out_ready_i |-> !in_ready_o)
    else $error("input ready while pipeline full and output stalled");

endmodule

bind hsv_color_confidence_classifier hcc_checker u_hcc_checker (.*);

// ===== sim/tb_hsv_color_confidence_classifier.sv =====
module tb_hsv_color_confidence_classifier;

  localparam int unsigned LevelW  = hcc_pkg::LevelW;
  localparam int unsigned ClassW  = hcc_pkg::ClassW;
  localparam int unsigned CfgIdxW = hcc_pkg::CfgIdxW;
  localparam int unsigned CfgW    = hcc_pkg::CfgW;
  localparam int unsigned MapSide = hcc_pkg::MapSide;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  // first register index with no register behind it
  localparam logic [CfgIdxW-1:0] NoRegIdx = 3'd5;

  typedef struct {
    logic              kind;
    logic [LevelW-1:0] blue;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] row;
    logic [LevelW-1:0] col;
    logic [ClassW-1:0] cls;
  } pix_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic kind_i = hcc_pkg::KindClassify;
  logic [LevelW-1:0] blue_level_i = '0;
  logic [LevelW-1:0] green_level_i = '0;
  logic [LevelW-1:0] red_level_i = '0;
  logic [LevelW-1:0] map_row_i = '0;
  logic [LevelW-1:0] map_col_i = '0;
  logic [ClassW-1:0] map_class_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [ClassW-1:0] confidence_class_o;

  hsv_color_confidence_classifier dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .kind_i             (kind_i),
    .blue_level_i       (blue_level_i),
    .green_level_i      (green_level_i),
    .red_level_i        (red_level_i),
    .map_row_i          (map_row_i),
    .map_col_i          (map_col_i),
    .map_class_i        (map_class_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .confidence_class_o (confidence_class_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow state of the classifier
  hcc_pkg::cfg_t     shadow_cfg;
  logic [ClassW-1:0] shadow_map [MapSide*MapSide];
  bit                map_loaded [MapSide*MapSide];  // entries already queued for writing

  pix_item_t         pixel_feed [$];
  logic [ClassW-1:0] class_due [$];
  pix_item_t         cur_px;

  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  int unsigned cycle_cnt = 0;
  int          err_cnt = 0;
  int          n_checked = 0;
  int          n_credible = 0;
  int          n_overexp = 0;
  int          n_map_writes = 0;
  int          n_settings = 0;
  logic [ClassW-1:0] want_class;

  function automatic longint recip_of(longint n);
    if (n <= 0) return 0;
    return (longint'(hcc_pkg::RecipNum) + n / 2) / n;
  endfunction

  function automatic logic [ClassW-1:0] classify_pixel(logic [LevelW-1:0] b,
                                                       logic [LevelW-1:0] g,
                                                       logic [LevelW-1:0] r);
    longint v, vmin, diff, tgt, sat, hue;
    logic [LevelW-1:0] row;
    v = longint'(b);
    vmin = longint'(b);
    if (longint'(g) > v) v = longint'(g);
    if (longint'(r) > v) v = longint'(r);
    tgt = shadow_cfg.target_is_blue ? longint'(b) : longint'(r);
    row = shadow_cfg.target_is_blue ? r : b;
    if (v <= longint'(shadow_cfg.value_floor)) return hcc_pkg::ClassNone;
    if (tgt >= longint'(hcc_pkg::OverLevel)) return shadow_map[{row, g}];
    if (longint'(g) < vmin) vmin = longint'(g);
    if (longint'(r) < vmin) vmin = longint'(r);
    diff = v - vmin;
    sat = (diff * recip_of(v)) >>> hcc_pkg::HsvShift;
    if (sat <= longint'(shadow_cfg.saturation_floor)) return hcc_pkg::ClassNone;
    if (v == longint'(r))
      hue = longint'(g) - longint'(b);
    else if (v == longint'(g))
      hue = longint'(b) - longint'(r) + 2 * diff;
    else
      hue = longint'(r) - longint'(g) + 4 * diff;
    // round half up, floor on negatives
    hue = (hue * recip_of(diff) * longint'(hcc_pkg::HueScale) +
           (longint'(1) <<< (hcc_pkg::HueShift - 1))) >>> hcc_pkg::HueShift;
    if (hue < 0) hue += longint'(hcc_pkg::HueRange);
    if (longint'(shadow_cfg.hue_low) < hue && hue < longint'(shadow_cfg.hue_high))
      return hcc_pkg::ClassCredible;
    return hcc_pkg::ClassNone;
  endfunction

  function automatic void queue_map_write(logic [LevelW-1:0] row, logic [LevelW-1:0] col,
                                          logic [ClassW-1:0] cls);
    pix_item_t it;
    it.kind = hcc_pkg::KindMapWrite;
    it.blue = LevelW'($urandom);
    it.green = LevelW'($urandom);
    it.red = LevelW'($urandom);
    it.row = row;
    it.col = col;
    it.cls = cls;
    map_loaded[{row, col}] = 1'b1;
    pixel_feed = {pixel_feed, it};
  endfunction

  // an overexposed pixel whose map entry is still blank gets it loaded first
  function automatic void queue_pixel(logic [LevelW-1:0] b, logic [LevelW-1:0] g,
                                      logic [LevelW-1:0] r);
    pix_item_t it;
    logic [LevelW-1:0] tgt, row;
    tgt = shadow_cfg.target_is_blue ? b : r;
    row = shadow_cfg.target_is_blue ? r : b;
    if (tgt >= hcc_pkg::OverLevel && !map_loaded[{row, g}])
      queue_map_write(row, g, ClassW'($urandom_range(0, 7)));
    it.kind = hcc_pkg::KindClassify;
    it.blue = b;
    it.green = g;
    it.red = r;
    it.row = LevelW'($urandom);
    it.col = LevelW'($urandom);
    it.cls = ClassW'($urandom);
    pixel_feed = {pixel_feed, it};
  endfunction

  function automatic void queue_random_item();
    int pick, tmp, j;
    int lv [3];
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      queue_map_write(LevelW'($urandom), LevelW'($urandom), ClassW'($urandom_range(0, 7)));
    end else if (pick < 35) begin
      lv[0] = $urandom_range(hcc_pkg::OverLevel, 255);
      lv[1] = $urandom_range(0, 255);
      lv[2] = $urandom_range(0, 255);
      if (shadow_cfg.target_is_blue)
        queue_pixel(LevelW'(lv[0]), LevelW'(lv[1]), LevelW'(lv[2]));
      else
        queue_pixel(LevelW'(lv[2]), LevelW'(lv[1]), LevelW'(lv[0]));
    end else if (pick < 75) begin
      // strongly saturated color, channels shuffled
      lv[0] = $urandom_range(0, 255);
      lv[2] = $urandom_range(0, lv[0] / 6);
      lv[1] = $urandom_range(lv[2], lv[0]);
      j = $urandom_range(0, 2);
      tmp = lv[0]; lv[0] = lv[j]; lv[j] = tmp;
      j = $urandom_range(1, 2);
      tmp = lv[1]; lv[1] = lv[j]; lv[j] = tmp;
      queue_pixel(LevelW'(lv[0]), LevelW'(lv[1]), LevelW'(lv[2]));
    end else begin
      queue_pixel(LevelW'($urandom), LevelW'($urandom), LevelW'($urandom));
    end
  endfunction

  // caller sits on a rising edge; valid is left high for a following write
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      hcc_pkg::CfgHueLow:       shadow_cfg.hue_low = val;
      hcc_pkg::CfgHueHigh:      shadow_cfg.hue_high = val;
      hcc_pkg::CfgTargetIsBlue: shadow_cfg.target_is_blue = val[0];
      hcc_pkg::CfgValueFloor:   shadow_cfg.value_floor = val;
      hcc_pkg::CfgSatFloor:     shadow_cfg.saturation_floor = val;
      default: ;
    endcase
  endtask

  task automatic set_config(hcc_pkg::cfg_t c, bit with_unused);
    @(posedge clk_i);
    write_reg(hcc_pkg::CfgHueLow, c.hue_low);
    write_reg(hcc_pkg::CfgHueHigh, c.hue_high);
    // upper data bits set on purpose, only bit 0 counts
    write_reg(hcc_pkg::CfgTargetIsBlue, {7'($urandom), c.target_is_blue});
    write_reg(hcc_pkg::CfgValueFloor, c.value_floor);
    write_reg(hcc_pkg::CfgSatFloor, c.saturation_floor);
    if (with_unused) begin
      for (int k = 0; k < 3; k++) write_reg(NoRegIdx + CfgIdxW'(k), CfgW'($urandom));
    end
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pixel_feed.size() != 0 || in_valid_i || class_due.size() != 0);
    // map writes leave no result behind, give them time to land
    repeat (hcc_pkg::PipeDepth + 2) @(posedge clk_i);
  endtask

  // pixel driver, predicts on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (cur_px.kind == hcc_pkg::KindMapWrite) begin
          shadow_map[{cur_px.row, cur_px.col}] =
              (cur_px.cls > hcc_pkg::MaxClass) ? hcc_pkg::ClassNone : cur_px.cls;
          n_map_writes++;
        end else begin
          class_due = {class_due, classify_pixel(cur_px.blue, cur_px.green, cur_px.red)};
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pixel_feed.size() > 0) begin
          cur_px = pixel_feed.pop_front();
          in_valid_i <= 1'b1;
          kind_i <= cur_px.kind;
          blue_level_i <= cur_px.blue;
          green_level_i <= cur_px.green;
          red_level_i <= cur_px.red;
          map_row_i <= cur_px.row;
          map_col_i <= cur_px.col;
          map_class_i <= cur_px.cls;
          if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 9);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (class_due.size() == 0) begin
          $error("confidence_class: unexpected result %0d", confidence_class_o);
          err_cnt++;
        end else begin
          want_class = class_due.pop_front();
          if (confidence_class_o !== want_class) begin
            $error("confidence_class: expected %0d, actual %0d", want_class, confidence_class_o);
            err_cnt++;
          end
          n_checked++;
          if (want_class == hcc_pkg::ClassCredible) n_credible++;
          if (want_class > hcc_pkg::ClassCredible) n_overexp++;
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("hsv_color_confidence_classifier test failed");
      $finish;
    end
  end

  initial begin
    hcc_pkg::cfg_t c;
    shadow_cfg = '{hcc_pkg::HueLowRst, hcc_pkg::HueHighRst, hcc_pkg::TargetBlueRst,
                   hcc_pkg::ValueFloorRst, hcc_pkg::SatFloorRst};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset settings: blue is the target, map row is red
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd127, 8'd0, 8'd0);      // max equals the value floor
    queue_pixel(8'd128, 8'd0, 8'd0);      // just above, hue out of window
    queue_pixel(8'd200, 8'd47, 8'd10);    // hue inside the window
    queue_pixel(8'd200, 8'd200, 8'd200);  // gray, no saturation
    queue_pixel(8'd50, 8'd0, 8'd200);     // red max, hue wraps negative
    queue_pixel(8'd0, 8'd255, 8'd0);      // green max
    queue_pixel(8'd0, 8'd0, 8'd255);
    queue_pixel(8'd249, 8'd0, 8'd0);      // one below overexposure
    queue_map_write(8'd255, 8'd255, 3'd4);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_map_write(8'd0, 8'd0, 3'd7);    // out-of-range class stores zero
    queue_pixel(8'd255, 8'd0, 8'd0);
    queue_map_write(8'd10, 8'd20, 3'd3);
    queue_pixel(8'd250, 8'd20, 8'd10);
    queue_map_write(8'd128, 8'd1, 3'd2);
    queue_pixel(8'd251, 8'd1, 8'd128);
    queue_map_write(8'd5, 8'd6, 3'd5);
    queue_pixel(8'd252, 8'd6, 8'd5);
    queue_map_write(8'd255, 8'd255, 3'd1); // overwrite, then read again
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_map_write(8'd0, 8'd0, 3'd6);
    queue_pixel(8'd255, 8'd0, 8'd0);
    wait_drained();

    // wide open window, no floors
    c = '{8'd0, 8'd255, 1'b1, 8'd0, 8'd0};
    set_config(c, 1'b0);
    repeat (100) queue_random_item();
    wait_drained();

    // opposite extremes, red target; unused indexes written too
    c = '{8'd255, 8'd0, 1'b0, 8'd255, 8'd255};
    set_config(c, 1'b1);
    repeat (30) queue_random_item();
    wait_drained();

    // red target, random thresholds, receiver holds off for a long stretch
    c.hue_low = LevelW'($urandom_range(0, 200));
    c.hue_high = LevelW'(c.hue_low + $urandom_range(2, 55));
    c.target_is_blue = 1'b0;
    c.value_floor = LevelW'($urandom_range(0, 200));
    c.saturation_floor = LevelW'($urandom_range(0, 230));
    set_config(c, 1'b0);
    repeat (125) queue_random_item();
    hold_req = 1'b1;
    wait_drained();

    c.hue_low = LevelW'($urandom_range(0, 200));
    c.hue_high = LevelW'(c.hue_low + $urandom_range(2, 55));
    c.target_is_blue = 1'b1;
    c.value_floor = 8'd100;
    c.saturation_floor = 8'd50;
    set_config(c, 1'b0);
    repeat (125) queue_random_item();
    wait_drained();

    // random settings with bounded floors, back to back on both sides
    c.hue_low = LevelW'($urandom);
    c.hue_high = LevelW'($urandom);
    c.target_is_blue = 1'($urandom);
    c.value_floor = LevelW'($urandom_range(0, 200));
    c.saturation_floor = LevelW'($urandom_range(0, 230));
    set_config(c, 1'b0);
    idle_on = 1'b0;
    repeat (125) queue_random_item();
    wait_drained();

    $display("%0d pixel classes checked (%0d credible, %0d from the overexposure map)",
             n_checked, n_credible, n_overexp);
    $display("%0d map writes over %0d register settings, idles, stalls and one long hold-off",
             n_map_writes, n_settings);
    if (err_cnt == 0) begin
      $display("hsv_color_confidence_classifier test passed");
    end else begin
      $display("hsv_color_confidence_classifier test failed");
    end
    $finish;
  end

endmodule
